FILE: rtl/prwu_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and routing functions of the permuting router
// no dependencies
package prwu_pkg;

    localparam logic [7:0] IDENTITY_MAP  = 8'hE4;
    localparam int         NUM_CHANGE    = 10;
    localparam logic [4:0] SHUFFLE_COUNT = 5'd24;

    // event numbers, one trigger bit each
    typedef enum logic [3:0] {
        EV_ROT_DN  = 4'd0,
        EV_ROT_UP  = 4'd1,
        EV_RESET   = 4'd2,
        EV_SWAP_12 = 4'd3,
        EV_SWAP_34 = 4'd4,
        EV_SWAP_23 = 4'd5,
        EV_SWAP_14 = 4'd6,
        EV_SWAP_13 = 4'd7,
        EV_SWAP_24 = 4'd8,
        EV_SHUFFLE = 4'd9,
        EV_UNDO    = 4'd10,
        EV_REDO    = 4'd11
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHANGE,
        ST_UNDO,
        ST_UNDO_LD,
        ST_REDO,
        ST_REDO_LD,
        ST_OUT
    } t_state;

    // classified control part of one item
    typedef struct packed {
        logic [3:0]  present;
        logic [11:0] trig;
        logic [7:0]  rand_map;
    } t_job_ctl;

    function automatic logic [7:0] rotate_map(input logic [7:0] map, input logic [1:0] delta);
        logic [7:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            r[2*k +: 2] = map[2*k +: 2] + delta;
        end
        return r;
    endfunction

    function automatic logic [7:0] swap_map(input logic [7:0] map, input logic [1:0] a,
                                            input logic [1:0] b);
        logic [7:0] r;
        logic [1:0] sa;
        logic [1:0] sb;
        sa = map[2*a +: 2];
        sb = map[2*b +: 2];
        r  = map;
        r[2*a +: 2] = sb;
        r[2*b +: 2] = sa;
        return r;
    endfunction

    // permutations of 0..3 in lexicographic order
    function automatic logic [7:0] perm_lookup(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:    r = 8'hE4;
            5'd1:    r = 8'hB4;
            5'd2:    r = 8'hD8;
            5'd3:    r = 8'h78;
            5'd4:    r = 8'h9C;
            5'd5:    r = 8'h6C;
            5'd6:    r = 8'hE1;
            5'd7:    r = 8'hB1;
            5'd8:    r = 8'hC9;
            5'd9:    r = 8'h39;
            5'd10:   r = 8'h8D;
            5'd11:   r = 8'h2D;
            5'd12:   r = 8'hD2;
            5'd13:   r = 8'h72;
            5'd14:   r = 8'hC6;
            5'd15:   r = 8'h36;
            5'd16:   r = 8'h4E;
            5'd17:   r = 8'h1E;
            5'd18:   r = 8'h93;
            5'd19:   r = 8'h63;
            5'd20:   r = 8'h87;
            5'd21:   r = 8'h27;
            5'd22:   r = 8'h4B;
            5'd23:   r = 8'h1B;
            default: r = IDENTITY_MAP;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] apply_change(input logic [7:0] map, input t_event ev,
                                                input logic [7:0] rand_map);
        logic [7:0] r;
        case (ev)
            EV_ROT_DN:  r = rotate_map(map, 2'd1);
            EV_ROT_UP:  r = rotate_map(map, 2'd3);
            EV_RESET:   r = IDENTITY_MAP;
            EV_SWAP_12: r = swap_map(map, 2'd0, 2'd1);
            EV_SWAP_34: r = swap_map(map, 2'd2, 2'd3);
            EV_SWAP_23: r = swap_map(map, 2'd1, 2'd2);
            EV_SWAP_14: r = swap_map(map, 2'd0, 2'd3);
            EV_SWAP_13: r = swap_map(map, 2'd0, 2'd2);
            EV_SWAP_24: r = swap_map(map, 2'd1, 2'd3);
            EV_SHUFFLE: r = rand_map;
            default:    r = map;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/prwu_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies
module prwu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/prwu_front.sv
`timescale 1ns / 1ps
// input stage: accepts items, unpacks them and resolves the shuffle choice
// depends on prwu_pkg
module prwu_front #(
    parameter int SAMPLE_BITS = 16,
    parameter int IN_BITS     = 88
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_BITS-1:0]       s_axis_tdata,
    output logic                     o_push,
    input  logic                     i_push_ready,
    output prwu_pkg::t_job_ctl       o_ctl,
    output logic [4*SAMPLE_BITS-1:0] o_samples
);
    import prwu_pkg::*;

    localparam int SB = SAMPLE_BITS;

    logic                r_valid;
    logic                n_valid;
    t_job_ctl            r_ctl;
    logic [4*SB-1:0]     r_samples;
    logic [4:0]          choice;
    logic [4:0]          choice_wrapped;
    logic                take;

    assign s_axis_tready = !r_valid || i_push_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign choice        = s_axis_tdata[4*SB+16 +: 5];
    // choices past the last permutation wrap around
    assign choice_wrapped = (choice >= SHUFFLE_COUNT) ? (choice - SHUFFLE_COUNT) : choice;

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_samples        <= s_axis_tdata[4*SB-1:0];
            r_ctl.present    <= s_axis_tdata[4*SB +: 4];
            r_ctl.trig       <= s_axis_tdata[4*SB+4 +: 12];
            r_ctl.rand_map   <= perm_lookup(choice_wrapped);
        end
    end

    assign o_push    = r_valid;
    assign o_ctl     = r_ctl;
    assign o_samples = r_samples;

endmodule

FILE: rtl/prwu_fifo.sv
`timescale 1ns / 1ps
// two-entry queue between the input stage and the event sequencer
// no dependencies
module prwu_fifo #(
    parameter int WIDTH = 88
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;
    assign o_data       = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

FILE: rtl/prwu_back.sv
`timescale 1ns / 1ps
// event sequencer: applies routing changes, undo and redo, then routes samples
// depends on prwu_pkg and prwu_ram
module prwu_back #(
    parameter int HISTORY_DEPTH = 128,
    parameter int SAMPLE_BITS   = 16,
    parameter int OUT_BITS      = 72
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_valid,
    output logic                     o_job_pop,
    input  prwu_pkg::t_job_ctl       i_job_ctl,
    input  logic [4*SAMPLE_BITS-1:0] i_job_samples,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_BITS-1:0]      m_axis_tdata
);
    import prwu_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX  = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(HISTORY_DEPTH);

    t_state               r_state, n_state;
    logic [7:0]           r_map, n_map;
    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_ucnt, n_ucnt;
    logic [CW-1:0]        r_rcnt, n_rcnt;
    logic signed [SB-1:0] r_held [4];
    logic signed [SB-1:0] n_held [4];
    logic [7:0]           r_out_map, n_out_map;
    logic                 r_out_valid, n_out_valid;

    t_job_ctl             r_ctl;
    logic [4*SB-1:0]      r_samples;
    logic [NUM_CHANGE-1:0] r_pend, n_pend;

    logic                 undo_we, undo_re, redo_we, redo_re;
    logic [AW-1:0]        undo_waddr, undo_raddr, redo_waddr, redo_raddr;
    logic [7:0]           undo_wdata, redo_wdata, undo_rdata, redo_rdata;
    logic [AW-1:0]        head_next, head_prev;
    t_event               first_ev;
    logic [1:0]           src;
    logic                 load_job;

    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST_IDX : r_head - 1'b1;

    // lowest pending change event goes first
    always_comb begin
        first_ev = EV_ROT_DN;
        for (int k = NUM_CHANGE - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                first_ev = t_event'(4'(k));
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_map       = r_map;
        n_head      = r_head;
        n_ucnt      = r_ucnt;
        n_rcnt      = r_rcnt;
        n_held      = r_held;
        n_out_map   = r_out_map;
        n_out_valid = r_out_valid;
        n_pend      = r_pend;
        load_job    = 1'b0;
        o_job_pop   = 1'b0;
        undo_we     = 1'b0;
        undo_waddr  = r_head;
        undo_wdata  = r_map;
        undo_re     = 1'b0;
        undo_raddr  = head_prev;
        redo_we     = 1'b0;
        redo_waddr  = r_rcnt[AW-1:0];
        redo_wdata  = r_map;
        redo_re     = 1'b0;
        redo_raddr  = AW'(r_rcnt - 1'b1);
        src         = 2'd0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    load_job  = 1'b1;
                    n_pend    = i_job_ctl.trig[NUM_CHANGE-1:0];
                    n_state   = ST_CHANGE;
                end
            end
            ST_CHANGE: begin
                if (r_pend != '0) begin
                    // old map goes onto the undo ring, redo history is dropped
                    undo_we = 1'b1;
                    n_head  = head_next;
                    if (r_ucnt != FULL_CNT) begin
                        n_ucnt = r_ucnt + 1'b1;
                    end
                    n_rcnt = '0;
                    n_map  = apply_change(r_map, first_ev, r_ctl.rand_map);
                    n_pend = r_pend & (r_pend - 1'b1);
                end else begin
                    n_state = ST_UNDO;
                end
            end
            ST_UNDO: begin
                n_state = ST_REDO;
                if (r_ctl.trig[EV_UNDO] && r_ucnt != '0) begin
                    undo_re = 1'b1;
                    n_head  = head_prev;
                    n_ucnt  = r_ucnt - 1'b1;
                    if (r_rcnt != FULL_CNT) begin
                        redo_we = 1'b1;
                        n_rcnt  = r_rcnt + 1'b1;
                    end
                    n_state = ST_UNDO_LD;
                end
            end
            ST_UNDO_LD: begin
                n_map   = undo_rdata;
                n_state = ST_REDO;
            end
            ST_REDO: begin
                n_state = ST_OUT;
                if (r_ctl.trig[EV_REDO] && r_rcnt != '0) begin
                    redo_re = 1'b1;
                    n_rcnt  = r_rcnt - 1'b1;
                    undo_we = 1'b1;
                    n_head  = head_next;
                    if (r_ucnt != FULL_CNT) begin
                        n_ucnt = r_ucnt + 1'b1;
                    end
                    n_state = ST_REDO_LD;
                end
            end
            ST_REDO_LD: begin
                n_map   = redo_rdata;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // held values double as the output register
                if (!r_out_valid || m_axis_tready) begin
                    for (int k = 0; k < 4; k++) begin
                        src = r_map[2*k +: 2];
                        if (r_ctl.present[src]) begin
                            case (src)
                                2'd0:    n_held[k] = r_samples[0*SB +: SB];
                                2'd1:    n_held[k] = r_samples[1*SB +: SB];
                                2'd2:    n_held[k] = r_samples[2*SB +: SB];
                                default: n_held[k] = r_samples[3*SB +: SB];
                            endcase
                        end
                    end
                    n_out_map   = r_map;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_map       <= IDENTITY_MAP;
            r_head      <= '0;
            r_ucnt      <= '0;
            r_rcnt      <= '0;
            r_held      <= '{default: '0};
            r_out_map   <= IDENTITY_MAP;
            r_out_valid <= 1'b0;
            r_pend      <= '0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_head      <= n_head;
            r_ucnt      <= n_ucnt;
            r_rcnt      <= n_rcnt;
            r_held      <= n_held;
            r_out_map   <= n_out_map;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_job) begin
            r_ctl     <= i_job_ctl;
            r_samples <= i_job_samples;
        end
    end

    prwu_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_undo_ram (
        .i_clk   (i_clk),
        .i_we    (undo_we),
        .i_waddr (undo_waddr),
        .i_wdata (undo_wdata),
        .i_re    (undo_re),
        .i_raddr (undo_raddr),
        .o_rdata (undo_rdata)
    );

    prwu_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_redo_ram (
        .i_clk   (i_clk),
        .i_we    (redo_we),
        .i_waddr (redo_waddr),
        .i_wdata (redo_wdata),
        .i_re    (redo_re),
        .i_raddr (redo_raddr),
        .o_rdata (redo_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_BITS'({r_out_map, r_held[3], r_held[2], r_held[1], r_held[0]});

endmodule

FILE: rtl/permuting_router_with_undo.sv
`timescale 1ns / 1ps
// 4-to-4 sample router with event-driven permutation and undo/redo history
// depends on prwu_pkg, prwu_front, prwu_fifo, prwu_back and prwu_ram
//
// One input item carries four samples, the connected-source mask, twelve
// trigger bits and a shuffle choice. The change events (rotations, reset,
// swaps, shuffle) are applied in bit order, each pushing the old map into
// the undo ring and clearing the redo stack; then undo, then redo. Each
// output takes the sample of its source if connected, else holds.
// An input register and a two-entry queue sit in front of the sequencer,
// so items are taken while the sequencer or the output is busy.
// The sequencer takes one item at a time: it loads the item, applies one
// change event per step, then does the undo step and the redo step, each
// with a history ram load step when it is actually done, then the output
// step. With the sequencer idle, an item taken passes the input register
// and the queue before the sequencer loads it.
// After reset the map is identity, both histories are empty and all held
// outputs are zero; no clearing pass is needed. When the receiver stalls
// the result waits in the output register, the sequencer finishes the
// next item up to its output step and then input backs up through the queue.
module permuting_router_with_undo #(
    parameter int HISTORY_DEPTH = 128,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // sample_a, sample_b, sample_c, sample_d, source_present, trigger_edges,
    // shuffle_choice, zero pad
    input  logic [((4*SAMPLE_BITS+21+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_a, out_b, out_c, out_d, routing, zero pad
    output logic [((4*SAMPLE_BITS+8+7)/8)*8-1:0]  m_axis_tdata
);
    import prwu_pkg::*;

    localparam int IN_BITS  = ((4*SAMPLE_BITS+21+7)/8)*8;
    localparam int OUT_BITS = ((4*SAMPLE_BITS+8+7)/8)*8;
    localparam int SMP_BITS = 4*SAMPLE_BITS;
    localparam int JOB_BITS = SMP_BITS + $bits(t_job_ctl);

    logic                push, push_ready, job_valid, job_pop;
    t_job_ctl            front_ctl, job_ctl;
    logic [SMP_BITS-1:0] front_samples, job_samples;
    logic [JOB_BITS-1:0] job_data;

    prwu_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_BITS     (IN_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .o_push        (push),
        .i_push_ready  (push_ready),
        .o_ctl         (front_ctl),
        .o_samples     (front_samples)
    );

    prwu_fifo #(
        .WIDTH (JOB_BITS)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .i_data       ({front_ctl, front_samples}),
        .o_valid      (job_valid),
        .i_pop        (job_pop),
        .o_data       (job_data)
    );

    assign job_samples = job_data[SMP_BITS-1:0];
    assign job_ctl     = t_job_ctl'(job_data[JOB_BITS-1:SMP_BITS]);

    prwu_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .OUT_BITS      (OUT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .o_job_pop     (job_pop),
        .i_job_ctl     (job_ctl),
        .i_job_samples (job_samples),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

FILE: verif/tb_permuting_router_with_undo.sv
`timescale 1ns / 1ps
// self-checking bench for permuting_router_with_undo: item stream in, routed samples out
// depends on prwu_pkg and the router rtl; carries its own routing and history predictor
module tb_permuting_router_with_undo;
    import prwu_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int HIST_DEPTH  = 128;
    localparam int IN_W        = ((4*SAMPLE_BITS+21+7)/8)*8;
    localparam int OUT_W       = ((4*SAMPLE_BITS+8+7)/8)*8;
    localparam int STALL_LIMIT = 4000;
    localparam int CLK_HALF    = 6;

    // lowest bits first: smp[0]..smp[3], present, trig, choice
    typedef struct packed {
        logic [4:0]                        choice;
        logic [11:0]                       trig;
        logic [3:0]                        present;
        logic [3:0][SAMPLE_BITS-1:0]       smp;
    } router_in_t;

    // lowest bits first: outs[0]..outs[3], routing
    typedef struct packed {
        logic [7:0]                        routing;
        logic [3:0][SAMPLE_BITS-1:0]       outs;
    } router_out_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    // predictor state
    logic [7:0]             cur_map;
    logic [7:0]             undo_ring [HIST_DEPTH];
    int                     undo_cnt;
    int                     undo_top;
    logic [7:0]             redo_stack [HIST_DEPTH];
    int                     redo_cnt;
    logic [SAMPLE_BITS-1:0] held [4];

    router_out_t routed_q [$];
    int          fail_count;
    bit          steady_flow;

    permuting_router_with_undo u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [7:0] rotated(input logic [7:0] map, input logic [1:0] delta);
        logic [7:0] r;
        for (int k = 0; k < 4; k++) begin
            r[2*k +: 2] = map[2*k +: 2] + delta;
        end
        return r;
    endfunction

    function automatic logic [7:0] swapped(input logic [7:0] map, input int a, input int b);
        logic [7:0] r;
        r = map;
        r[2*a +: 2] = map[2*b +: 2];
        r[2*b +: 2] = map[2*a +: 2];
        return r;
    endfunction

    // n-th permutation of 0..3 in lexicographic order, built digit by digit
    function automatic logic [7:0] lex_perm(input logic [4:0] idx);
        int         rest;
        int         pick;
        int         left [4];
        int         weight [4];
        logic [7:0] m;
        weight = '{6, 2, 1, 1};
        left   = '{0, 1, 2, 3};
        rest   = int'(idx);
        m      = '0;
        for (int j = 0; j < 4; j++) begin
            pick = rest / weight[j];
            rest = rest % weight[j];
            m[2*j +: 2] = 2'(left[pick]);
            for (int i = pick; i < 3; i++) begin
                left[i] = left[i+1];
            end
        end
        return m;
    endfunction

    function automatic void push_undo(input logic [7:0] map);
        undo_ring[undo_top] = map;
        undo_top = (undo_top + 1 >= HIST_DEPTH) ? 0 : undo_top + 1;
        if (undo_cnt < HIST_DEPTH) begin
            undo_cnt++;
        end
    endfunction

    function automatic router_out_t apply_triggers_and_route(input router_in_t it);
        router_out_t r;
        logic [4:0]  sel;
        logic [7:0]  prev;
        logic [1:0]  src;
        for (int e = 0; e < 10; e++) begin
            if (it.trig[e]) begin
                push_undo(cur_map);
                redo_cnt = 0;
                case (t_event'(4'(e)))
                    EV_ROT_DN:  cur_map = rotated(cur_map, 2'd1);
                    EV_ROT_UP:  cur_map = rotated(cur_map, 2'd3);
                    EV_RESET:   cur_map = IDENTITY_MAP;
                    EV_SWAP_12: cur_map = swapped(cur_map, 0, 1);
                    EV_SWAP_34: cur_map = swapped(cur_map, 2, 3);
                    EV_SWAP_23: cur_map = swapped(cur_map, 1, 2);
                    EV_SWAP_14: cur_map = swapped(cur_map, 0, 3);
                    EV_SWAP_13: cur_map = swapped(cur_map, 0, 2);
                    EV_SWAP_24: cur_map = swapped(cur_map, 1, 3);
                    EV_SHUFFLE: begin
                        sel = (it.choice >= SHUFFLE_COUNT) ? it.choice - SHUFFLE_COUNT
                                                           : it.choice;
                        cur_map = lex_perm(sel);
                    end
                    default:    cur_map = cur_map;
                endcase
            end
        end
        if (it.trig[EV_UNDO] && undo_cnt > 0) begin
            undo_top = (undo_top == 0) ? HIST_DEPTH - 1 : undo_top - 1;
            undo_cnt--;
            prev = undo_ring[undo_top];
            if (redo_cnt < HIST_DEPTH) begin
                redo_stack[redo_cnt] = cur_map;
                redo_cnt++;
            end
            cur_map = prev;
        end
        if (it.trig[EV_REDO] && redo_cnt > 0) begin
            redo_cnt--;
            prev = redo_stack[redo_cnt];
            push_undo(cur_map);
            cur_map = prev;
        end
        for (int k = 0; k < 4; k++) begin
            src = cur_map[2*k +: 2];
            if (it.present[src]) begin
                held[k] = it.smp[src];
            end
            r.outs[k] = held[k];
        end
        r.routing = cur_map;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic [SAMPLE_BITS-1:0] corner [4];
        corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 7) == 0) begin
            return corner[$urandom_range(0, 3)];
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic router_in_t random_item(input logic [11:0] trig);
        router_in_t it;
        for (int k = 0; k < 4; k++) begin
            it.smp[k] = random_sample();
        end
        it.present = 4'($urandom_range(0, 15));
        it.trig    = trig;
        it.choice  = 5'($urandom_range(0, 31));
        return it;
    endfunction

    // holds tvalid high after acceptance so back-to-back items need no re-raise
    task automatic send_item(input router_in_t it);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(it);
        do @(posedge i_clk); while (!s_axis_tready);
        routed_q.insert(routed_q.size(), apply_triggers_and_route(it));
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_empty_history();
        router_in_t it;
        send_item(random_item(12'b1 << EV_UNDO));
        send_item(random_item(12'b1 << EV_REDO));
        // nothing connected: outputs hold their previous values
        it = random_item('0);
        it.present = 4'h0;
        it.smp     = {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001};
        send_item(it);
    endtask

    task automatic test_each_event();
        router_in_t it;
        for (int e = 0; e < 12; e++) begin
            it = random_item(12'b1 << e);
            it.present = 4'hF;
            it.smp     = {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
            send_item(it);
        end
    endtask

    task automatic test_shuffle_wrap();
        router_in_t it;
        logic [4:0] picks [3];
        picks = '{5'd24, 5'd31, 5'd23};
        for (int i = 0; i < 3; i++) begin
            it = random_item(12'b1 << EV_SHUFFLE);
            it.choice = picks[i];
            send_item(it);
        end
    endtask

    task automatic test_combined_events();
        router_in_t it;
        it = random_item(12'hFFF);
        it.present = 4'hA;
        send_item(it);
        it = random_item(12'hFFF);
        it.present = 4'h5;
        send_item(it);
        it = random_item((12'b1 << EV_SWAP_13) | (12'b1 << EV_UNDO) | (12'b1 << EV_REDO));
        it.present = 4'hF;
        send_item(it);
    endtask

    // overflow the undo ring, unwind past empty, then redo past empty
    task automatic test_history_overflow();
        int n_fill;
        n_fill = HIST_DEPTH + $urandom_range(10, 40);
        repeat (n_fill) send_item(random_item(12'b1 << $urandom_range(0, 9)));
        repeat (HIST_DEPTH + 8) send_item(random_item(12'b1 << EV_UNDO));
        repeat (HIST_DEPTH + 4) send_item(random_item(12'b1 << EV_REDO));
        repeat (30) send_item(random_item((12'b1 << EV_UNDO) | (12'b1 << EV_REDO)));
    endtask

    task automatic test_drain_pause();
        repeat (20) send_item(random_item(12'b1 << $urandom_range(0, 11)));
        stop_sending();
        while (routed_q.size() != 0) @(posedge i_clk);
        repeat (20) send_item(random_item(12'($urandom_range(0, 4095))));
    endtask

    task automatic test_random_mix(input int n_items);
        logic [11:0] trig;
        int          sent;
        int          run_len;
        sent = 0;
        while (sent < n_items) begin
            steady_flow = (sent >= 300 && sent < 550);
            if ($urandom_range(0, 39) == 0) begin
                // undo run followed by a redo run
                run_len = $urandom_range(5, 30);
                repeat (run_len) send_item(random_item(12'b1 << EV_UNDO));
                repeat ($urandom_range(1, run_len + 3))
                    send_item(random_item(12'b1 << EV_REDO));
                sent += 2 * run_len;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2: trig = '0;
                    3, 4, 5: trig = 12'b1 << $urandom_range(0, 9);
                    6:       trig = 12'b1 << EV_UNDO;
                    7:       trig = 12'b1 << EV_REDO;
                    8:       trig = 12'($urandom_range(0, 4095));
                    default: trig = (12'b1 << $urandom_range(0, 11))
                                  | (12'b1 << $urandom_range(0, 11));
                endcase
                send_item(random_item(trig));
                sent++;
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge i_clk) begin : check_results
        router_out_t got;
        router_out_t want;
        string       names [4];
        names = '{"out_a", "out_b", "out_c", "out_d"};
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(router_out_t)-1:0];
            if (routed_q.size() == 0) begin
                $error("unexpected result: routing %h", got.routing);
                fail_count++;
            end else begin
                want = routed_q[0];
                routed_q.delete(0);
                for (int k = 0; k < 4; k++) begin
                    if (got.outs[k] !== want.outs[k]) begin
                        $error("%s: expected %0d, actual %0d", names[k],
                               $signed(want.outs[k]), $signed(got.outs[k]));
                        fail_count++;
                    end
                end
                if (got.routing !== want.routing) begin
                    $error("routing: expected %h, actual %h", want.routing, got.routing);
                    fail_count++;
                end
            end
        end
    end

    // ends the run when nothing moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady_flow   = 1'b0;
        fail_count    = 0;
        cur_map       = IDENTITY_MAP;
        undo_cnt      = 0;
        undo_top      = 0;
        redo_cnt      = 0;
        for (int k = 0; k < 4; k++) begin
            held[k] = '0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_history();
        test_each_event();
        test_shuffle_wrap();
        test_combined_events();
        test_history_overflow();
        test_drain_pause();
        test_random_mix(1400);

        stop_sending();
        while (routed_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
